// File: rtl/core/egu_pkg.sv
// Shared types, codes, saturation helpers and the microcode ROM of the gradient unit.
package egu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int FUNC_W        = 3;
	localparam int SCALE_W       = 18;
	localparam int UPC_W         = 5;

	localparam logic [SCALE_W-1:0] SCALE_RST = 18'd131072;

	// operation codes carried by an item
	localparam logic [FUNC_W-1:0] F_SIGMOID    = 3'd0;
	localparam logic [FUNC_W-1:0] F_RELU       = 3'd1;
	localparam logic [FUNC_W-1:0] F_ADD        = 3'd2;
	localparam logic [FUNC_W-1:0] F_SUB        = 3'd3;
	localparam logic [FUNC_W-1:0] F_HADAMARD   = 3'd4;
	localparam logic [FUNC_W-1:0] F_MSE        = 3'd5;
	localparam logic [FUNC_W-1:0] F_SMAX_SUM   = 3'd6;
	localparam logic [FUNC_W-1:0] F_SMAX_APPLY = 3'd7;

	// multiplier operand selects
	localparam logic [1:0] MA_G = 2'd0;
	localparam logic [1:0] MA_Y = 2'd1;
	localparam logic [1:0] MA_U = 2'd2;
	localparam logic [1:0] MA_T = 2'd3;

	localparam logic [2:0] MB_Y     = 3'd0;
	localparam logic [2:0] MB_BV    = 3'd1;
	localparam logic [2:0] MB_AV    = 3'd2;
	localparam logic [2:0] MB_T     = 3'd3;
	localparam logic [2:0] MB_SCALE = 3'd4;

	// temporary register sources
	localparam logic [1:0] T_NONE        = 2'd0;
	localparam logic [1:0] T_ONE_MINUS_Y = 2'd1;
	localparam logic [1:0] T_AV_MINUS_BV = 2'd2;
	localparam logic [1:0] T_G_MINUS_SUM = 2'd3;

	// gradient updates
	localparam logic [1:0] A_NONE   = 2'd0;
	localparam logic [1:0] A_ADD_G  = 2'd1;
	localparam logic [1:0] A_ADD_PF = 2'd2;

	localparam logic [2:0] B_NONE   = 3'd0;
	localparam logic [2:0] B_ADD_G  = 3'd1;
	localparam logic [2:0] B_SUB_G  = 3'd2;
	localparam logic [2:0] B_ADD_PF = 3'd3;
	localparam logic [2:0] B_SUB_PF = 3'd4;

	// sequencing
	localparam logic [1:0] BR_NEXT  = 2'd0;
	localparam logic [1:0] BR_JNPOS = 2'd1;
	localparam logic [1:0] BR_END   = 2'd2;

	// program entry points
	localparam logic [UPC_W-1:0] PC_SIG  = 5'd0;
	localparam logic [UPC_W-1:0] PC_RELU = 5'd4;
	localparam logic [UPC_W-1:0] PC_ADD  = 5'd7;
	localparam logic [UPC_W-1:0] PC_SUB  = 5'd8;
	localparam logic [UPC_W-1:0] PC_HAD  = 5'd9;
	localparam logic [UPC_W-1:0] PC_MSE  = 5'd12;
	localparam logic [UPC_W-1:0] PC_SUM  = 5'd15;
	localparam logic [UPC_W-1:0] PC_APP  = 5'd17;

	typedef struct packed {
		logic             mul_en;
		logic [1:0]       ma_sel;
		logic [2:0]       mb_sel;
		logic [1:0]       t_op;
		logic             u_en;
		logic [1:0]       a_op;
		logic [2:0]       b_op;
		logic             sum_acc;
		logic [1:0]       br;
		logic             emit;
		logic [UPC_W-1:0] target;
	} egu_uword_t;

	typedef struct packed {
		logic       fire;
		egu_uword_t uw;
	} egu_ctl_t;

	typedef struct packed {
		logic av_pos;
		logic out_free;
	} egu_stat_t;

	localparam egu_uword_t UW_NOP = '0;

	function automatic logic signed [DATA_W-1:0] sat33(input logic signed [DATA_W:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[DATA_W] != v[DATA_W-1]) begin
			r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat64(input logic signed [2*DATA_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		logic                     fits;
		fits = (&v[2*DATA_W-1:DATA_W-1]) | ~(|v[2*DATA_W-1:DATA_W-1]);
		if (!fits) begin
			r = v[2*DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [UPC_W-1:0] egu_entry(input logic [FUNC_W-1:0] func);
		logic [UPC_W-1:0] pc;
		unique case (func)
			F_SIGMOID:    pc = PC_SIG;
			F_RELU:       pc = PC_RELU;
			F_ADD:        pc = PC_ADD;
			F_SUB:        pc = PC_SUB;
			F_HADAMARD:   pc = PC_HAD;
			F_MSE:        pc = PC_MSE;
			F_SMAX_SUM:   pc = PC_SUM;
			F_SMAX_APPLY: pc = PC_APP;
		endcase
		return pc;
	endfunction

	// product from a step is taken (floored, saturated) as pf in the following step
	function automatic egu_uword_t egu_rom(input logic [UPC_W-1:0] pc);
		egu_uword_t w;
		w = UW_NOP;
		unique case (pc)
			PC_SIG: begin
				w.t_op   = T_ONE_MINUS_Y;
				w.mul_en = 1'b1;
				w.ma_sel = MA_G;
				w.mb_sel = MB_Y;
			end
			PC_SIG + 5'd1: begin
				w.u_en = 1'b1;
			end
			PC_SIG + 5'd2: begin
				w.mul_en = 1'b1;
				w.ma_sel = MA_U;
				w.mb_sel = MB_T;
			end
			PC_SIG + 5'd3: begin
				w.a_op = A_ADD_PF;
				w.br   = BR_END;
				w.emit = 1'b1;
			end
			PC_RELU: begin
				w.br     = BR_JNPOS;
				w.target = PC_RELU + 5'd2;
			end
			PC_RELU + 5'd1: begin
				w.a_op = A_ADD_G;
				w.br   = BR_END;
				w.emit = 1'b1;
			end
			PC_RELU + 5'd2: begin
				w.br   = BR_END;
				w.emit = 1'b1;
			end
			PC_ADD: begin
				w.a_op = A_ADD_G;
				w.b_op = B_ADD_G;
				w.br   = BR_END;
				w.emit = 1'b1;
			end
			PC_SUB: begin
				w.a_op = A_ADD_G;
				w.b_op = B_SUB_G;
				w.br   = BR_END;
				w.emit = 1'b1;
			end
			PC_HAD: begin
				w.mul_en = 1'b1;
				w.ma_sel = MA_G;
				w.mb_sel = MB_BV;
			end
			PC_HAD + 5'd1: begin
				w.mul_en = 1'b1;
				w.ma_sel = MA_G;
				w.mb_sel = MB_AV;
				w.a_op   = A_ADD_PF;
			end
			PC_HAD + 5'd2: begin
				w.b_op = B_ADD_PF;
				w.br   = BR_END;
				w.emit = 1'b1;
			end
			PC_MSE: begin
				w.t_op = T_AV_MINUS_BV;
			end
			PC_MSE + 5'd1: begin
				w.mul_en = 1'b1;
				w.ma_sel = MA_T;
				w.mb_sel = MB_SCALE;
			end
			PC_MSE + 5'd2: begin
				w.a_op = A_ADD_PF;
				w.b_op = B_SUB_PF;
				w.br   = BR_END;
				w.emit = 1'b1;
			end
			PC_SUM: begin
				w.mul_en = 1'b1;
				w.ma_sel = MA_G;
				w.mb_sel = MB_Y;
			end
			PC_SUM + 5'd1: begin
				w.sum_acc = 1'b1;
				w.br      = BR_END;
			end
			PC_APP: begin
				w.t_op = T_G_MINUS_SUM;
			end
			PC_APP + 5'd1: begin
				w.mul_en = 1'b1;
				w.ma_sel = MA_Y;
				w.mb_sel = MB_T;
			end
			PC_APP + 5'd2: begin
				w.a_op = A_ADD_PF;
				w.br   = BR_END;
				w.emit = 1'b1;
			end
			default: begin
				w.br = BR_END;
			end
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/egu_if.sv
// Item and result channel interfaces of the gradient unit.
interface egu_item_if import egu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic signed [DATA_W-1:0] out_grad;
	logic signed [DATA_W-1:0] out_value;
	logic signed [DATA_W-1:0] a_value;
	logic signed [DATA_W-1:0] b_value;
	logic signed [DATA_W-1:0] a_grad_in;
	logic signed [DATA_W-1:0] b_grad_in;
	logic                     first_of_pass;

	modport source (
		output valid, func, out_grad, out_value, a_value, b_value,
		       a_grad_in, b_grad_in, first_of_pass,
		input  ready
	);
	modport sink (
		input  valid, func, out_grad, out_value, a_value, b_value,
		       a_grad_in, b_grad_in, first_of_pass,
		output ready
	);
endinterface

interface egu_result_if import egu_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] a_grad_out;
	logic signed [DATA_W-1:0] b_grad_out;

	modport source (output valid, a_grad_out, b_grad_out, input ready);
	modport sink (input valid, a_grad_out, b_grad_out, output ready);
endinterface

// File: rtl/core/egu_seq.sv
// Microcode sequencer: step counter, program ROM and branch logic.
module egu_seq import egu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FUNC_W-1:0] func,
	input  egu_stat_t         stat,
	output logic              busy,
	output egu_ctl_t          ctl
);

	logic [UPC_W-1:0] pc_q;
	logic             busy_q;
	egu_uword_t       uw;
	logic             stall;

	assign uw    = egu_rom(pc_q);
	// hold the final step until the output register can take the result
	assign stall = (uw.br == BR_END) && uw.emit && !stat.out_free;

	assign ctl.uw   = uw;
	assign ctl.fire = busy_q & ~stall;
	assign busy     = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= egu_entry(func);
		end else if (ctl.fire) begin
			unique case (uw.br)
				BR_NEXT:  pc_q <= pc_q + 5'd1;
				BR_JNPOS: pc_q <= stat.av_pos ? pc_q + 5'd1 : uw.target;
				BR_END:   busy_q <= 1'b0;
				default:  busy_q <= 1'b0;
			endcase
		end
	end

endmodule

// File: rtl/core/egu_dp.sv
// Datapath: operand registers, shared multiplier, saturating adders, softmax sum, result register.
module egu_dp import egu_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	egu_item_if.sink           item,
	egu_result_if.source       result,
	input  logic               cfg_wen,
	input  logic [SCALE_W-1:0] cfg_wdata,
	input  logic               busy,
	input  egu_ctl_t           ctl,
	output logic               start,
	output logic [FUNC_W-1:0]  func,
	output egu_stat_t          stat
);

	localparam logic signed [DATA_W:0] ONE_VAL = 33'sd1 <<< FRACTION_BITS;

	logic signed [DATA_W-1:0]   g_q, y_q, av_q, bv_q, a_q, b_q;
	logic                       first_q;
	logic signed [DATA_W-1:0]   t_q, u_q, sum_q;
	logic signed [2*DATA_W-1:0] prod_q;
	logic [SCALE_W-1:0]         scale_q;
	logic                       res_valid_q;
	logic signed [DATA_W-1:0]   res_a_q, res_b_q;

	logic signed [2*DATA_W-1:0] prod_sh;
	logic signed [DATA_W-1:0]   pf, ma, mb, t_d, a_nx, b_nx, sum_base, sum_nx;
	logic                       end_emit;

	assign item.ready = ~busy;
	assign start      = item.valid & ~busy;
	assign func       = item.func;

	assign prod_sh = prod_q >>> FRACTION_BITS;
	assign pf      = sat64(prod_sh);

	always_comb begin
		unique case (ctl.uw.ma_sel)
			MA_G:    ma = g_q;
			MA_Y:    ma = y_q;
			MA_U:    ma = u_q;
			MA_T:    ma = t_q;
			default: ma = g_q;
		endcase
		unique case (ctl.uw.mb_sel)
			MB_Y:     mb = y_q;
			MB_BV:    mb = bv_q;
			MB_AV:    mb = av_q;
			MB_T:     mb = t_q;
			MB_SCALE: mb = $signed({{(DATA_W-SCALE_W){1'b0}}, scale_q});
			default:  mb = y_q;
		endcase
	end

	always_comb begin
		unique case (ctl.uw.t_op)
			T_ONE_MINUS_Y: t_d = sat33(ONE_VAL - {y_q[DATA_W-1], y_q});
			T_AV_MINUS_BV: t_d = sat33({av_q[DATA_W-1], av_q} - {bv_q[DATA_W-1], bv_q});
			T_G_MINUS_SUM: t_d = sat33({g_q[DATA_W-1], g_q} - {sum_q[DATA_W-1], sum_q});
			default:       t_d = t_q;
		endcase
	end

	always_comb begin
		unique case (ctl.uw.a_op)
			A_ADD_G:  a_nx = sat33({a_q[DATA_W-1], a_q} + {g_q[DATA_W-1], g_q});
			A_ADD_PF: a_nx = sat33({a_q[DATA_W-1], a_q} + {pf[DATA_W-1], pf});
			default:  a_nx = a_q;
		endcase
		unique case (ctl.uw.b_op)
			B_ADD_G:  b_nx = sat33({b_q[DATA_W-1], b_q} + {g_q[DATA_W-1], g_q});
			B_SUB_G:  b_nx = sat33({b_q[DATA_W-1], b_q} - {g_q[DATA_W-1], g_q});
			B_ADD_PF: b_nx = sat33({b_q[DATA_W-1], b_q} + {pf[DATA_W-1], pf});
			B_SUB_PF: b_nx = sat33({b_q[DATA_W-1], b_q} - {pf[DATA_W-1], pf});
			default:  b_nx = b_q;
		endcase
	end

	// a sum item that opens a pass drops the kept sum
	assign sum_base = first_q ? '0 : sum_q;
	assign sum_nx   = sat33({sum_base[DATA_W-1], sum_base} + {pf[DATA_W-1], pf});

	assign end_emit = ctl.fire && (ctl.uw.br == BR_END) && ctl.uw.emit;

	assign stat.av_pos   = (av_q > 0);
	assign stat.out_free = ~res_valid_q | result.ready;

	assign result.valid      = res_valid_q;
	assign result.a_grad_out = res_a_q;
	assign result.b_grad_out = res_b_q;

	always_ff @(posedge clk) begin
		if (start) begin
			g_q     <= item.out_grad;
			y_q     <= item.out_value;
			av_q    <= item.a_value;
			bv_q    <= item.b_value;
			a_q     <= item.a_grad_in;
			b_q     <= item.b_grad_in;
			first_q <= item.first_of_pass;
		end else if (ctl.fire) begin
			a_q <= a_nx;
			b_q <= b_nx;
			t_q <= t_d;
			if (ctl.uw.u_en) begin
				u_q <= pf;
			end
			if (ctl.uw.mul_en) begin
				prod_q <= ma * mb;
			end
		end
		if (end_emit) begin
			res_a_q <= a_nx;
			res_b_q <= b_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= SCALE_RST;
			sum_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				scale_q <= cfg_wdata;
			end
			if (ctl.fire && ctl.uw.sum_acc) begin
				sum_q <= sum_nx;
			end
			if (end_emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/elementwise_gradient_unit_core.sv
// Top level of the gradient unit: sequencer, datapath and their checks.
//
//   channel   dir   handshake        payload
//   item      in    valid / ready    func, out_grad, out_value, a_value, b_value,
//                                    a_grad_in, b_grad_in, first_of_pass
//   result    out   valid / ready    a_grad_out, b_grad_out
//   cfg       in    cfg_wen          cfg_wdata (mse_scale)
//
// One item at a time: the item transfers, then runs one to four microcode steps; the
// shared 32x32 multiplier and its product register set the step count.
// A result waits in the output register; the next item transfers while it waits, and
// only a final step that would overwrite an untaken result stalls.
// Reset clears the sequencer, the softmax sum, the result valid and restores mse_scale.
module elementwise_gradient_unit_core import egu_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	egu_item_if.sink           item,
	egu_result_if.source       result,
	input  logic               cfg_wen,
	input  logic [SCALE_W-1:0] cfg_wdata
);

	logic              start;
	logic [FUNC_W-1:0] func;
	logic              busy;
	egu_ctl_t          ctl;
	egu_stat_t         stat;

	egu_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	egu_dp #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.busy      (busy),
		.ctl       (ctl),
		.start     (start),
		.func      (func),
		.stat      (stat)
	);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy)
		else $error("sequencer did not start on item transfer");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.fire && ctl.uw.br == BR_END && ctl.uw.emit) |=> result.valid)
		else $error("final step did not load the result register");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !ctl.fire)
		else $error("datapath step while sequencer idle");

	a_end_only: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(ctl.fire && ctl.uw.br == BR_END))
		else $error("sequencer went idle without a final step");

endmodule

// File: dv/egu_grad_checker.sv
// Checker that predicts the gradient results from the item transfers and compares them.
module egu_grad_checker import egu_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	egu_item_if                item,
	egu_result_if              result,
	input  logic               cfg_wen,
	input  logic [SCALE_W-1:0] cfg_wdata,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint LIM_HI = 64'sd2147483647;
	localparam longint LIM_LO = -64'sd2147483648;

	typedef struct packed {
		logic signed [DATA_W-1:0] a;
		logic signed [DATA_W-1:0] b;
	} grad_pair_t;

	grad_pair_t         grad_q[$];
	logic [SCALE_W-1:0] mse_scale;
	longint             dot_sum;

	function automatic longint clamp(input longint v);
		if (v > LIM_HI) begin
			return LIM_HI;
		end
		if (v < LIM_LO) begin
			return LIM_LO;
		end
		return v;
	endfunction

	// floor the product to the fixed-point grid, then saturate
	function automatic longint qmul(input longint x, input longint y);
		longint p;
		p = x * y;
		return clamp(p >>> FRACTION_BITS);
	endfunction

	task automatic flag(input string what, input longint want, input longint got);
		if (errors < 10) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
		end
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		grad_pair_t want;
		longint     g, y, av, bv, ag, bg, t, one;
		logic       emit;
		if (!arst_n) begin
			grad_q.delete();
			mse_scale = SCALE_RST;
			dot_sum   = 0;
			errors    = 0;
			pending   = 0;
		end else begin
			if (cfg_wen) begin
				mse_scale = cfg_wdata;
			end
			if (result.valid && result.ready) begin
				if (grad_q.size() == 0) begin
					if (errors < 10) begin
						$display("%0t: result transfer with nothing expected: a %0d b %0d",
							$realtime, result.a_grad_out, result.b_grad_out);
					end
					errors++;
				end else begin
					want = grad_q.pop_front();
					if (want.a !== result.a_grad_out) begin
						flag("a_grad_out", want.a, result.a_grad_out);
					end
					if (want.b !== result.b_grad_out) begin
						flag("b_grad_out", want.b, result.b_grad_out);
					end
				end
			end
			if (item.valid && item.ready) begin
				g    = item.out_grad;
				y    = item.out_value;
				av   = item.a_value;
				bv   = item.b_value;
				ag   = item.a_grad_in;
				bg   = item.b_grad_in;
				one  = longint'(1) <<< FRACTION_BITS;
				emit = 1'b1;
				case (item.func)
					F_SIGMOID: begin
						ag = clamp(ag + qmul(qmul(g, y), clamp(one - y)));
					end
					F_RELU: begin
						if (av > 0) begin
							ag = clamp(ag + g);
						end
					end
					F_ADD: begin
						ag = clamp(ag + g);
						bg = clamp(bg + g);
					end
					F_SUB: begin
						ag = clamp(ag + g);
						bg = clamp(bg - g);
					end
					F_HADAMARD: begin
						t  = qmul(g, bv);
						bg = clamp(bg + qmul(g, av));
						ag = clamp(ag + t);
					end
					F_MSE: begin
						t  = qmul(clamp(av - bv), longint'(mse_scale));
						ag = clamp(ag + t);
						bg = clamp(bg - t);
					end
					F_SMAX_SUM: begin
						// accumulate only, no result for this transfer
						if (item.first_of_pass) begin
							dot_sum = 0;
						end
						dot_sum = clamp(dot_sum + qmul(g, y));
						emit    = 1'b0;
					end
					F_SMAX_APPLY: begin
						ag = clamp(ag + qmul(y, clamp(g - dot_sum)));
					end
					default: begin
					end
				endcase
				if (emit) begin
					want.a = ag[DATA_W-1:0];
					want.b = bg[DATA_W-1:0];
					grad_q.push_back(want);
				end
			end
			pending = grad_q.size();
		end
	end

endmodule

// File: dv/tb.sv
// Top of the gradient unit testbench: clock, reset, item and config stimulus, verdict.
module tb import egu_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd1 <<< FRAC_BITS_DEF;
	localparam int PHASE_ITEMS = 200;
	localparam int SETTLE_CYCLES = 8;

	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [SCALE_W-1:0] cfg_wdata;
	int                 tx_idle_pct;
	int                 rx_stall_pct;
	int                 items_sent;
	int                 chk_errors;
	int                 chk_pending;

	logic [SCALE_W-1:0] phase_scale [8] = '{18'd0, 18'h3FFFF, SCALE_RST, 18'd0,
		18'd1, 18'h10000, 18'd0, 18'h3FFFF};
	int tx_pct [4] = '{0, 88, 0, 23};
	int rx_pct [4] = '{0, 0, 88, 23};

	egu_item_if   item_ch ();
	egu_result_if res_ch ();

	elementwise_gradient_unit_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (res_ch),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	egu_grad_checker #(.FRACTION_BITS(FRAC_BITS_DEF)) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (res_ch),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.errors    (chk_errors),
		.pending   (chk_pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		res_ch.ready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
	end

	function automatic logic signed [DATA_W-1:0] rnd_q();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6, 7: return $urandom_range(0, 8 * Q_ONE) - 4 * Q_ONE;
			8: begin
				case ($urandom_range(0, 4))
					0: return Q_MAX;
					1: return Q_MIN;
					2: return '0;
					3: return Q_ONE;
					default: return -Q_ONE;
				endcase
			end
			default: begin
				if ($urandom_range(0, 1)) begin
					return Q_MAX - $urandom_range(0, 255);
				end
				return Q_MIN + $urandom_range(0, 255);
			end
		endcase
	endfunction

	// call at a falling edge; returns at the falling edge after the transfer
	task automatic offer_item(input logic [FUNC_W-1:0] f,
			input logic signed [DATA_W-1:0] g, y, av, bv, ag, bg, input logic fp);
		while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid         <= 1'b1;
		item_ch.func          <= f;
		item_ch.out_grad      <= g;
		item_ch.out_value     <= y;
		item_ch.a_value       <= av;
		item_ch.b_value       <= bv;
		item_ch.a_grad_in     <= ag;
		item_ch.b_grad_in     <= bg;
		item_ch.first_of_pass <= fp;
		items_sent++;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	// hold the sender until every result is in and a trailing sum item has finished
	task automatic settle_results();
		item_ch.valid <= 1'b0;
		while (chk_pending != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_mse_scale(input logic [SCALE_W-1:0] v);
		settle_results();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic softmax_group();
		int n_sum;
		int n_app;
		n_sum = $urandom_range(1, 6);
		n_app = $urandom_range(1, 6);
		// mostly a clean pass; now and then the clear is dropped or a stray one shows up
		for (int i = 0; i < n_sum; i++) begin
			offer_item(F_SMAX_SUM, rnd_q(), rnd_q(), rnd_q(), rnd_q(), rnd_q(), rnd_q(),
				(i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 9) == 0));
		end
		for (int i = 0; i < n_app; i++) begin
			offer_item(F_SMAX_APPLY, rnd_q(), rnd_q(), rnd_q(), rnd_q(), rnd_q(), rnd_q(),
				1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		int target;
		item_ch.valid         = 1'b0;
		item_ch.func          = F_SIGMOID;
		item_ch.out_grad      = '0;
		item_ch.out_value     = '0;
		item_ch.a_value       = '0;
		item_ch.b_value       = '0;
		item_ch.a_grad_in     = '0;
		item_ch.b_grad_in     = '0;
		item_ch.first_of_pass = 1'b0;
		res_ch.ready          = 1'b0;
		cfg_wen               = 1'b0;
		cfg_wdata             = SCALE_RST;
		tx_idle_pct           = 0;
		rx_stall_pct          = 0;
		items_sent            = 0;
		arst_n                = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// apply before any sum pass uses the cleared sum
		offer_item(F_SMAX_APPLY, 2 * Q_ONE, Q_ONE / 2, 0, 0, Q_ONE, -Q_ONE, 1'b0);
		offer_item(F_SIGMOID, Q_ONE, Q_ONE / 2, 0, 0, 0, 7, 1'b0);
		offer_item(F_SIGMOID, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b0);
		offer_item(F_SIGMOID, Q_MIN, Q_MAX, 0, 0, Q_MIN, Q_MAX, 1'b0);
		offer_item(F_RELU, Q_MAX, 0, 1, 0, Q_MAX, 5, 1'b0);
		offer_item(F_RELU, Q_MAX, 0, 0, 0, 3, 5, 1'b0);
		offer_item(F_RELU, Q_MIN, 0, Q_MIN, Q_MAX, Q_MIN, 5, 1'b0);
		offer_item(F_ADD, Q_MAX, 0, 0, 0, Q_MAX, Q_MIN, 1'b0);
		offer_item(F_ADD, Q_MIN, 0, 0, 0, Q_MIN, Q_MIN, 1'b0);
		offer_item(F_SUB, Q_MIN, 0, 0, 0, 0, Q_MAX, 1'b0);
		offer_item(F_HADAMARD, Q_MAX, 0, Q_MAX, Q_MIN, 0, 0, 1'b0);
		offer_item(F_HADAMARD, -1, 0, Q_MIN, 1, -Q_ONE, Q_ONE, 1'b0);
		offer_item(F_MSE, Q_MAX, 0, Q_MAX, Q_MIN, 0, 0, 1'b0);
		offer_item(F_MSE, Q_MIN, 0, Q_MIN, Q_MAX, Q_MAX, Q_MIN, 1'b0);
		offer_item(F_MSE, 12345, 0, -3, 0, 0, 0, 1'b0);
		offer_item(F_SMAX_SUM, Q_ONE, 2 * Q_ONE, 0, 0, 0, 0, 1'b1);
		offer_item(F_SMAX_SUM, Q_MAX, Q_MAX, 0, 0, 0, 0, 1'b0);
		offer_item(F_SMAX_APPLY, 0, Q_ONE, 0, 0, 0, 9, 1'b0);
		offer_item(F_SMAX_SUM, Q_MIN, Q_MAX, 0, 0, 0, 0, 1'b1);
		offer_item(F_SMAX_SUM, Q_MIN, Q_MAX, 0, 0, 0, 0, 1'b0);
		offer_item(F_SMAX_APPLY, Q_MAX, -Q_ONE, 0, 0, Q_MIN, 0, 1'b0);
		offer_item(F_RELU, 3, 0, 5, 0, 1, 2, 1'b1);
		offer_item(F_ADD, 0, 0, 0, 0, 4, 6, 1'b1);
		offer_item(F_SMAX_SUM, 0, 0, 0, 0, 0, 0, 1'b1);
		offer_item(F_SMAX_APPLY, 1, 1, 0, 0, 0, 0, 1'b0);

		phase_scale[3] = SCALE_W'($urandom_range(0, 18'h3FFFF));
		phase_scale[6] = SCALE_W'($urandom_range(0, 18'h3FFFF));
		for (int phase = 0; phase < 8; phase++) begin
			load_mse_scale(phase_scale[phase]);
			tx_idle_pct  = tx_pct[phase % 4];
			rx_stall_pct = rx_pct[phase % 4];
			target       = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				if ($urandom_range(0, 149) == 0) begin
					settle_results();
				end
				if ($urandom_range(0, 99) < 8) begin
					softmax_group();
				end else begin
					offer_item(3'($urandom_range(0, 7)), rnd_q(), rnd_q(), rnd_q(), rnd_q(),
						rnd_q(), rnd_q(), 1'($urandom_range(0, 1)));
				end
			end
		end

		settle_results();
		if (chk_errors == 0 && chk_pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// File: elementwise_gradient_unit_core.f
rtl/core/egu_pkg.sv
rtl/core/egu_if.sv
rtl/core/egu_seq.sv
rtl/core/egu_dp.sv
rtl/core/elementwise_gradient_unit_core.sv
dv/egu_grad_checker.sv
dv/tb.sv
